/* design/generational_sparse_set_store_macros.svh */
// Assertion macros used by the sparse set store sequencer.
`ifndef GENERATIONAL_SPARSE_SET_STORE_MACROS_SVH
`define GENERATIONAL_SPARSE_SET_STORE_MACROS_SVH

// Checks that a property holds at every rising edge outside reset.
`define GSSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is never seen at a rising edge outside reset.
`define GSSS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* design/gsss_pkg.sv */
// Package with types, codes and default sizes for the sparse set store.
package gsss_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int COORD_BITS_DEF  = 16;
  localparam int GEN_BITS_DEF    = 16;

  localparam int FUNC_W  = 3;
  localparam int ENT_W   = 10;
  localparam int GENF_W  = 16;
  localparam int XY_W    = 16;
  localparam int SLOT_W  = 10;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 11;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD    = 3'd0,
    FN_REMOVE = 3'd1,
    FN_LOOKUP = 3'd2,
    FN_OWNER  = 3'd3,
    FN_CLEAR  = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_MISS    = 3'd1,
    STAT_PRESENT = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_RANGE   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_RDLAST,
    S_MOVE,
    S_RDDENSE,
    S_SWEEP
  } state_e;

  typedef struct packed {
    status_e              status;
    logic [SLOT_W-1:0]    slot;
    logic [XY_W-1:0]      x;
    logic [XY_W-1:0]      y;
    logic [ENT_W-1:0]     owner;
    logic [COUNT_W-1:0]   count;
  } res_t;

endpackage

/* design/gsss_ram.sv */
// Simple dual-port synchronous RAM with one write and one registered read port.
module gsss_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/gsss_seq.sv */
// Operation sequencer: reads, checks and writes back the sparse and dense maps.
`include "generational_sparse_set_store_macros.svh"

module gsss_seq #(
  parameter int MAX_ENTRIES = 1024,
  parameter int COORD_BITS  = 16,
  parameter int GEN_BITS    = 16,
  localparam int IDX_W      = $clog2(MAX_ENTRIES),
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1),
  localparam int SW         = 1 + GEN_BITS + IDX_W,
  localparam int DW         = IDX_W + 2 * COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [gsss_pkg::FUNC_W-1:0]   func_i,
  input  logic [gsss_pkg::ENT_W-1:0]    entity_index_i,
  input  logic [gsss_pkg::GENF_W-1:0]   generation_i,
  input  logic signed [gsss_pkg::XY_W-1:0] x_in_i,
  input  logic signed [gsss_pkg::XY_W-1:0] y_in_i,
  input  logic [gsss_pkg::SLOT_W-1:0]   slot_in_i,
  output logic                          res_valid_o,
  output gsss_pkg::res_t                res_o,
  output logic                          s_we_o,
  output logic [IDX_W-1:0]              s_waddr_o,
  output logic [SW-1:0]                 s_wdata_o,
  output logic [IDX_W-1:0]              s_raddr_o,
  input  logic [SW-1:0]                 s_rdata_i,
  output logic                          d_we_o,
  output logic [IDX_W-1:0]              d_waddr_o,
  output logic [DW-1:0]                 d_wdata_o,
  output logic [IDX_W-1:0]              d_raddr_o,
  input  logic [DW-1:0]                 d_rdata_i
);

  import gsss_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] SWEEP_END = IDX_W'(MAX_ENTRIES - 1);

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [IDX_W-1:0]        sweep_q, sweep_d;
  func_e                   func_q, func_d;
  logic [IDX_W-1:0]        ent_q, ent_d;
  logic [GEN_BITS-1:0]     gen_q, gen_d;
  logic [2*COORD_BITS-1:0] pair_q, pair_d;
  logic [IDX_W-1:0]        hole_q, hole_d;
  logic [DW-1:0]           mv_q, mv_d;

  // Fields of the sparse word {valid, generation, slot}.
  logic                    sp_valid;
  logic [GEN_BITS-1:0]     sp_gen;
  logic [IDX_W-1:0]        sp_slot;
  logic                    hit;
  logic [CNT_W-1:0]        last_cnt;
  logic [IDX_W-1:0]        tail_slot;
  logic                    ent_ok;
  logic                    slot_ok;
  logic [COORD_BITS-1:0]   rd_x, rd_y;

  assign sp_valid  = s_rdata_i[SW-1];
  assign sp_gen    = s_rdata_i[SW-2 -: GEN_BITS];
  assign sp_slot   = s_rdata_i[IDX_W-1:0];
  assign hit       = sp_valid && (sp_gen == gen_q) && (CNT_W'(sp_slot) < count_q);
  assign last_cnt  = count_q - CNT_W'(1);
  assign tail_slot = IDX_W'(last_cnt);
  assign ent_ok    = 32'(entity_index_i) < 32'(MAX_ENTRIES);
  assign slot_ok   = 32'(slot_in_i) < 32'(count_q);
  assign rd_x      = d_rdata_i[COORD_BITS-1:0];
  assign rd_y      = d_rdata_i[2*COORD_BITS-1:COORD_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      count_q <= '0;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sweep_q <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    ent_q  <= ent_d;
    gen_q  <= gen_d;
    pair_q <= pair_d;
    hole_q <= hole_d;
    mv_q   <= mv_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sweep_d     = sweep_q;
    func_d      = func_q;
    ent_d       = ent_q;
    gen_d       = gen_q;
    pair_d      = pair_q;
    hole_d      = hole_q;
    mv_d        = mv_q;
    s_we_o      = 1'b0;
    s_waddr_o   = ent_q;
    s_wdata_o   = '0;
    s_raddr_o   = ent_q;
    d_we_o      = 1'b0;
    d_waddr_o   = hole_q;
    d_wdata_o   = mv_q;
    d_raddr_o   = hole_q;
    res_valid_o = 1'b0;
    res_o.status = STAT_MISS;
    res_o.slot   = '0;
    res_o.x      = '0;
    res_o.y      = '0;
    res_o.owner  = '0;
    res_o.count  = COUNT_W'(count_q);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d    = func_e'(func_i);
          ent_d     = IDX_W'(entity_index_i);
          gen_d     = GEN_BITS'(generation_i);
          pair_d    = {COORD_BITS'(y_in_i), COORD_BITS'(x_in_i)};
          hole_d    = IDX_W'(slot_in_i);
          s_raddr_o = IDX_W'(entity_index_i);
          d_raddr_o = IDX_W'(slot_in_i);
          case (func_i)
            FN_ADD, FN_REMOVE, FN_LOOKUP: begin
              if (ent_ok) begin
                state_d = S_CHK;
              end else begin
                res_valid_o = 1'b1;
              end
            end
            FN_OWNER: begin
              if (slot_ok) begin
                state_d = S_RDDENSE;
              end else begin
                res_valid_o  = 1'b1;
                res_o.status = STAT_RANGE;
              end
            end
            FN_CLEAR: begin
              // Report at once, then wipe every valid bit while busy.
              count_d      = '0;
              sweep_d      = '0;
              res_valid_o  = 1'b1;
              res_o.status = STAT_OK;
              res_o.count  = '0;
              state_d      = S_SWEEP;
            end
            default: begin
              res_valid_o = 1'b1;
            end
          endcase
        end
      end

      S_CHK: begin
        case (func_q)
          FN_ADD: begin
            res_valid_o = 1'b1;
            state_d     = S_IDLE;
            if (sp_valid && (sp_gen == gen_q)) begin
              res_o.status = STAT_PRESENT;
            end else if (count_q == MAX_CNT) begin
              res_o.status = STAT_FULL;
            end else begin
              d_we_o       = 1'b1;
              d_waddr_o    = IDX_W'(count_q);
              d_wdata_o    = {ent_q, pair_q};
              s_we_o       = 1'b1;
              s_waddr_o    = ent_q;
              s_wdata_o    = {1'b1, gen_q, IDX_W'(count_q)};
              count_d      = count_q + CNT_W'(1);
              res_o.status = STAT_OK;
              res_o.slot   = SLOT_W'(count_q);
              res_o.count  = COUNT_W'(count_d);
            end
          end
          FN_REMOVE: begin
            if (!hit) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
            end else begin
              s_we_o    = 1'b1;
              s_waddr_o = ent_q;
              s_wdata_o = {1'b0, sp_gen, sp_slot};
              count_d   = last_cnt;
              hole_d    = sp_slot;
              if (sp_slot < tail_slot) begin
                d_raddr_o = tail_slot;
                state_d   = S_RDLAST;
              end else begin
                res_valid_o  = 1'b1;
                res_o.status = STAT_OK;
                res_o.slot   = SLOT_W'(sp_slot);
                res_o.count  = COUNT_W'(last_cnt);
                state_d      = S_IDLE;
              end
            end
          end
          FN_LOOKUP: begin
            if (!hit) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
            end else begin
              hole_d    = sp_slot;
              d_raddr_o = sp_slot;
              state_d   = S_RDDENSE;
            end
          end
          default: begin
            res_valid_o = 1'b1;
            state_d     = S_IDLE;
          end
        endcase
      end

      S_RDLAST: begin
        // The last entry moves into the hole; fetch its owner's sparse word.
        mv_d      = d_rdata_i;
        s_raddr_o = d_rdata_i[DW-1 -: IDX_W];
        state_d   = S_MOVE;
      end

      S_MOVE: begin
        s_we_o       = 1'b1;
        s_waddr_o    = mv_q[DW-1 -: IDX_W];
        s_wdata_o    = {sp_valid, sp_gen, hole_q};
        d_we_o       = 1'b1;
        d_waddr_o    = hole_q;
        d_wdata_o    = mv_q;
        res_valid_o  = 1'b1;
        res_o.status = STAT_OK;
        res_o.slot   = SLOT_W'(hole_q);
        state_d      = S_IDLE;
      end

      S_RDDENSE: begin
        res_valid_o  = 1'b1;
        res_o.status = STAT_OK;
        if (func_q == FN_LOOKUP) begin
          res_o.slot = SLOT_W'(hole_q);
          res_o.x    = XY_W'(rd_x);
          res_o.y    = XY_W'(rd_y);
        end else begin
          res_o.owner = ENT_W'(d_rdata_i[DW-1 -: IDX_W]);
        end
        state_d = S_IDLE;
      end

      S_SWEEP: begin
        s_we_o    = 1'b1;
        s_waddr_o = sweep_q;
        s_wdata_o = '0;
        if (sweep_q == SWEEP_END) begin
          state_d = S_IDLE;
        end else begin
          sweep_d = sweep_q + IDX_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  `GSSS_NEVER(a_count_bound, count_q > MAX_CNT, "live count above table size")
  `GSSS_ASSERT(a_move_below_count, (state_q == S_MOVE) |-> (CNT_W'(hole_q) < count_q),
    "moved entry does not land below the live count")
  `GSSS_ASSERT(a_add_grows, (state_q == S_CHK && func_q == FN_ADD && res_o.status == STAT_OK)
    |=> (count_q == $past(count_q) + CNT_W'(1)), "successful add did not grow the count")
  `GSSS_ASSERT(a_res_ends_op, res_valid_o |=> (state_q == S_IDLE || state_q == S_SWEEP),
    "sequencer still working after its result")
  `GSSS_NEVER(a_sweep_quiet, (state_q == S_SWEEP) && res_valid_o,
    "result produced during the clearing pass")

endmodule

/* design/generational_sparse_set_store.sv */
// Top level of the generational sparse set store of coordinate pairs.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+---------------------------------------
//  command  | in        | start, busy            | func, entity_index, generation, x_in,
//           |           |                        | y_in, slot_in
//  result   | out       | done_o (one-cycle)     | status, slot_out, x_out, y_out,
//           |           |                        | owner_out, count_out
//
// A command transfer takes place at a rising edge with start high and busy low.
// Its result transfer follows in the state that ends the command: S_IDLE for clear, an
// unknown code, an out-of-range entity and an owner query past the end; S_RDDENSE for an
// owner query; S_CHK for an add, a miss and a remove of the last entry; S_CHK, S_RDDENSE
// for a lookup hit; S_CHK, S_RDLAST, S_MOVE for a remove that moves the last entry. Clear
// then holds busy in S_SWEEP to reset every valid bit, as after reset. The receiver cannot stall.
module generational_sparse_set_store #(
  parameter int MAX_ENTRIES = gsss_pkg::MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = gsss_pkg::COORD_BITS_DEF,
  parameter int GEN_BITS    = gsss_pkg::GEN_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [gsss_pkg::FUNC_W-1:0]      func_i,
  input  logic [gsss_pkg::ENT_W-1:0]       entity_index_i,
  input  logic [gsss_pkg::GENF_W-1:0]      generation_i,
  input  logic signed [gsss_pkg::XY_W-1:0] x_in_i,
  input  logic signed [gsss_pkg::XY_W-1:0] y_in_i,
  input  logic [gsss_pkg::SLOT_W-1:0]      slot_in_i,
  output logic                             done_o,
  output logic [gsss_pkg::STAT_W-1:0]      status_o,
  output logic [gsss_pkg::SLOT_W-1:0]      slot_out_o,
  output logic signed [gsss_pkg::XY_W-1:0] x_out_o,
  output logic signed [gsss_pkg::XY_W-1:0] y_out_o,
  output logic [gsss_pkg::ENT_W-1:0]       owner_out_o,
  output logic [gsss_pkg::COUNT_W-1:0]     count_out_o
);

  import gsss_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  // Sparse word: valid bit, stored generation and dense slot of an entity.
  localparam int SW    = 1 + GEN_BITS + IDX_W;
  // Dense word: owning entity and the packed (y, x) pair.
  localparam int DW    = IDX_W + 2 * COORD_BITS;

  logic             s_we, d_we;
  logic [IDX_W-1:0] s_waddr, s_raddr, d_waddr, d_raddr;
  logic [SW-1:0]    s_wdata, s_rdata;
  logic [DW-1:0]    d_wdata, d_rdata;
  logic             res_valid;
  res_t             res;

  // Result output register; done_q is the one-cycle strobe.
  logic             done_q;
  res_t             res_q;

  gsss_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (SW)
  ) u_sparse (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  gsss_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (DW)
  ) u_dense (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  gsss_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS),
    .GEN_BITS    (GEN_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .func_i         (func_i),
    .entity_index_i (entity_index_i),
    .generation_i   (generation_i),
    .x_in_i         (x_in_i),
    .y_in_i         (y_in_i),
    .slot_in_i      (slot_in_i),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .s_we_o         (s_we),
    .s_waddr_o      (s_waddr),
    .s_wdata_o      (s_wdata),
    .s_raddr_o      (s_raddr),
    .s_rdata_i      (s_rdata),
    .d_we_o         (d_we),
    .d_waddr_o      (d_waddr),
    .d_wdata_o      (d_wdata),
    .d_raddr_o      (d_raddr),
    .d_rdata_i      (d_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign done_o      = done_q;
  assign status_o    = res_q.status;
  assign slot_out_o  = res_q.slot;
  assign x_out_o     = res_q.x;
  assign y_out_o     = res_q.y;
  assign owner_out_o = res_q.owner;
  assign count_out_o = res_q.count;

endmodule
